FILE: hdl/opt_pkg.sv
// Shared types and constants for the ordered pair table.
`timescale 1ns / 1ps

package opt_pkg;

  localparam int CAPACITY     = 16;
  localparam int TYPE_WIDTH   = 8;
  localparam int ENTITY_WIDTH = 16;
  localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;
  localparam logic [1:0] OP_HALF   = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [TYPE_WIDTH-1:0]   type_a;
    logic [TYPE_WIDTH-1:0]   type_b;
    logic [ENTITY_WIDTH-1:0] entity_a;
    logic [ENTITY_WIDTH-1:0] entity_b;
  } item_t;

  typedef struct packed {
    logic                    found;
    logic [ENTITY_WIDTH-1:0] entity_low_side;
    logic [ENTITY_WIDTH-1:0] entity_high_side;
    logic [ENTITY_WIDTH-1:0] entity_half;
    logic                    nonempty;
    logic                    overflow;
  } result_t;

  typedef struct packed {
    logic [TYPE_WIDTH-1:0]   type_low;
    logic [TYPE_WIDTH-1:0]   type_high;
    logic [ENTITY_WIDTH-1:0] entity_low;
    logic [ENTITY_WIDTH-1:0] entity_high;
  } entry_t;

endpackage

FILE: hdl/opt_store.sv
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module opt_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [opt_pkg::IDX_W-1:0] wr_addr,
  input  opt_pkg::entry_t          wr_entry,
  input  logic [opt_pkg::IDX_W-1:0] rd_addr,
  output opt_pkg::entry_t          rd_entry
);
  import opt_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

FILE: hdl/ordered_pair_table.sv
// Ordered pair table: top level with the scan and shift sequencer.
// A lookup makes one memory read per entry until it finds a match; a remove
// scans to the match and then moves each later entry down one slot.
// One transaction is processed at a time; the result register lets the next
// transaction be accepted while a result is still waiting. Reset empties the
// table and sets the miss value to all ones; the memory itself is not cleared.
`timescale 1ns / 1ps

module ordered_pair_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  opt_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output opt_pkg::result_t            result,
  input  logic                        null_valid,
  output logic                        null_ready,
  input  logic [opt_pkg::ENTITY_WIDTH-1:0] null_data
);
  import opt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t                  state;
  logic [1:0]              op;
  entry_t                  key;
  logic [TYPE_WIDTH-1:0]   half_key;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        rd_pos;
  logic                    rd_vld;
  logic [ENTITY_WIDTH-1:0] null_value;
  result_t                 res;
  result_t                 result_next;
  entry_t                  canon;
  entry_t                  rd_entry;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_entry;
  logic [CNT_W-1:0]        pos_m1;
  logic                    hit;
  logic                    more;

  assign item_stall = (state != S_IDLE);
  assign null_ready = 1'b1;
  assign more       = (idx < cnt);
  assign pos_m1     = rd_pos - CNT_W'(1);

  always_comb begin
    if (item.type_a < item.type_b) begin
      canon = '{item.type_a, item.type_b, item.entity_a, item.entity_b};
    end else begin
      canon = '{item.type_b, item.type_a, item.entity_b, item.entity_a};
    end
  end

  always_comb begin
    case (op)
      OP_REMOVE: hit = (rd_entry == key);
      OP_PAIR:   hit = (rd_entry.type_low == key.type_low) &&
                       (rd_entry.type_high == key.type_high);
      OP_HALF:   hit = (rd_entry.type_low == half_key) ||
                       (rd_entry.type_high == half_key);
      default:   hit = 1'b0;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos_m1[IDX_W-1:0];
    wr_entry = rd_entry;
    if (state == S_ADD) begin
      wr_en    = (cnt != CNT_W'(CAPACITY));
      wr_addr  = cnt[IDX_W-1:0];
      wr_entry = key;
    end else if (state == S_SHIFT) begin
      wr_en = rd_vld;
    end
  end

  always_comb begin
    result_next          = res;
    result_next.nonempty = (cnt != '0);
  end

  opt_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (idx[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      null_value <= '1;
    end else if (null_valid && null_ready) begin
      null_value <= null_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      idx          <= '0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // The done state decides the result flag itself when it is active.
      if (!result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op       <= item.operation;
            key      <= canon;
            half_key <= item.type_a;
            idx      <= '0;
            rd_vld   <= 1'b0;
            res      <= '{1'b0, null_value, null_value, null_value, 1'b0, 1'b0};
            state    <= (item.operation == OP_ADD) ? S_ADD : S_SCAN;
          end
        end
        S_ADD: begin
          if (cnt == CNT_W'(CAPACITY)) begin
            res.overflow <= 1'b1;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (rd_vld && hit) begin
            res.found <= 1'b1;
            rd_vld    <= 1'b0;
            if (op == OP_PAIR) begin
              res.entity_low_side  <= rd_entry.entity_low;
              res.entity_high_side <= rd_entry.entity_high;
            end
            if (op == OP_HALF) begin
              // The low side wins when both sides hold the key.
              res.entity_half <= (rd_entry.type_low == half_key) ?
                                 rd_entry.entity_low : rd_entry.entity_high;
            end
            if (op == OP_REMOVE) begin
              idx   <= rd_pos + CNT_W'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (!rd_vld && !more) begin
            state <= S_DONE;
          end else begin
            rd_vld <= more;
            rd_pos <= idx;
            if (more) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_SHIFT: begin
          // Each entry read here is written one slot lower on the next cycle.
          if (!rd_vld && !more) begin
            cnt   <= cnt - CNT_W'(1);
            state <= S_DONE;
          end else begin
            rd_vld <= more;
            rd_pos <= idx;
            if (more) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && rd_vld) |-> (rd_pos != '0))
    else $error("shift writes below slot zero");

  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.overflow && result.found))
    else $error("overflow reported together with a match");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != S_IDLE))
    else $error("accepted transaction not taken up");

endmodule
